FILE: src/rrpt_pkg.sv
// ----------------------------------------------------------------------------
// rrpt_pkg - shared types for the round-robin process table
// Slot entry layout, event codes, status codes, sequencer states and the
// request bundle between the sequencer and the slot memory.
// ----------------------------------------------------------------------------
package rrpt_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int ID_W           = 4;   // slot ids on the ports
  localparam int ID_SPACE       = 16;  // ids reachable with ID_W bits

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_ADMIT   = 3'd1,
    OP_BLOCK   = 3'd2,
    OP_UNBLOCK = 3'd3,
    OP_WAIT    = 3'd4,
    OP_KILL    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_NOREADY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SLOT_FREE   = 2'd0,
    SLOT_READY  = 2'd1,
    SLOT_LOCKED = 2'd2
  } slot_state_t;

  typedef struct packed {
    slot_state_t       state;
    logic              waiting;
    logic [ID_W-1:0]   awaited;
    logic [ID_W-1:0]   parent;
  } entry_t;

  localparam entry_t RESET_ENTRY = '{state: SLOT_FREE, waiting: 1'b0,
                                     awaited: '0, parent: '0};

  typedef struct packed {
    logic              rd_en;
    logic [ID_W-1:0]   rd_addr;
    logic              wr_en;
    logic [ID_W-1:0]   wr_addr;
    entry_t            wr_data;
  } mem_req_t;

  typedef struct packed {
    logic [ID_W-1:0]   running_pid;
    logic [ID_W-1:0]   new_pid;
    status_t           status;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RMW_WR,
    S_KILL_PAR,
    S_KILL_PCHK,
    S_KILL_TRD,
    S_KILL_TWR,
    S_SCAN,
    S_RESP
  } ctrl_state_t;

  // Number of slots that ids can reach.
  function automatic int nslot_of(input int slot_count);
    return (slot_count < ID_SPACE) ? slot_count : ID_SPACE;
  endfunction

  function automatic logic in_range(input logic [ID_W-1:0] id, input int n);
    return int'(id) < n;
  endfunction

endpackage

FILE: src/rrpt_table.sv
// ----------------------------------------------------------------------------
// rrpt_table - slot memory
// One entry per slot, synchronous read: the read entry is registered. A valid
// bit per entry makes never-written entries read as the reset entry.
// ----------------------------------------------------------------------------
module rrpt_table
  import rrpt_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  mem_req_t req,
  output entry_t   rdata
);

  localparam int NSLOT = nslot_of(SLOT_COUNT);
  localparam int IDX_W = $clog2(NSLOT);

  entry_t           mem [NSLOT];
  entry_t           rd_q;
  logic             rd_valid;
  logic [NSLOT-1:0] valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[IDX_W-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q <= mem[req.rd_addr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid[req.wr_addr[IDX_W-1:0]] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid <= valid[req.rd_addr[IDX_W-1:0]];
      end
    end
  end

  assign rdata = rd_valid ? rd_q : RESET_ENTRY;

endmodule

FILE: src/rrpt_ctrl.sv
// ----------------------------------------------------------------------------
// rrpt_ctrl - event sequencer
// Reads, modifies and writes back slot entries for each event and runs the
// slot scan used by admit and by rescheduling, one read issued per cycle.
// ----------------------------------------------------------------------------
module rrpt_ctrl
  import rrpt_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  op_t             in_op,
  input  logic [ID_W-1:0] in_tgt,
  input  logic [ID_W-1:0] in_oth,
  output logic            res_valid,
  input  logic            res_ready,
  output res_t            res,
  output mem_req_t        req,
  input  entry_t          mem_rdata
);

  localparam int NSLOT = nslot_of(SLOT_COUNT);
  localparam int IDX_W = $clog2(NSLOT);
  localparam int CNT_W = $clog2(NSLOT + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NSLOT - 1);
  localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(NSLOT);

  ctrl_state_t      state, state_next;
  op_t              op, op_next;
  logic [ID_W-1:0]  tgt, tgt_next;
  logic [ID_W-1:0]  oth, oth_next;
  logic [ID_W-1:0]  par, par_next;
  logic [IDX_W-1:0] scan_addr, scan_addr_next;
  logic [CNT_W-1:0] scan_cnt, scan_cnt_next;
  logic             pend, pend_next;
  logic [IDX_W-1:0] pend_addr, pend_addr_next;
  logic [IDX_W-1:0] running, running_next;
  logic [ID_W-1:0]  new_id, new_id_next;
  status_t          status, status_next;
  logic             scan_go;
  logic             match;
  entry_t           wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      running <= '0;
      pend    <= 1'b0;
    end else begin
      state   <= state_next;
      running <= running_next;
      pend    <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    op        <= op_next;
    tgt       <= tgt_next;
    oth       <= oth_next;
    par       <= par_next;
    scan_addr <= scan_addr_next;
    scan_cnt  <= scan_cnt_next;
    pend_addr <= pend_addr_next;
    new_id    <= new_id_next;
    status    <= status_next;
  end

  always_comb begin
    state_next     = state;
    op_next        = op;
    tgt_next       = tgt;
    oth_next       = oth;
    par_next       = par;
    scan_addr_next = scan_addr;
    scan_cnt_next  = scan_cnt;
    pend_next      = 1'b0;
    pend_addr_next = pend_addr;
    running_next   = running;
    new_id_next    = new_id;
    status_next    = status;
    scan_go        = 1'b0;
    req            = '0;
    wdata          = mem_rdata;
    match          = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next     = in_op;
          tgt_next    = in_tgt;
          oth_next    = in_oth;
          new_id_next = '0;
          status_next = STAT_OK;
          case (in_op)
            OP_TICK, OP_ADMIT: begin
              scan_go = 1'b1;
            end
            OP_BLOCK, OP_UNBLOCK: begin
              if (in_range(in_tgt, NSLOT)) begin
                req.rd_en   = 1'b1;
                req.rd_addr = in_tgt;
                state_next  = S_RMW_WR;
              end else if (in_op == OP_BLOCK) begin
                scan_go = 1'b1;
              end else begin
                state_next = S_RESP;
              end
            end
            OP_WAIT: begin
              if (in_range(in_oth, NSLOT)) begin
                req.rd_en   = 1'b1;
                req.rd_addr = in_oth;
                state_next  = S_RMW_WR;
              end else begin
                scan_go = 1'b1;
              end
            end
            OP_KILL: begin
              if (in_range(in_tgt, NSLOT)) begin
                req.rd_en   = 1'b1;
                req.rd_addr = in_tgt;
                state_next  = S_KILL_PAR;
              end else begin
                scan_go = 1'b1;
              end
            end
            default: begin
              state_next = S_RESP;
            end
          endcase
        end
      end

      S_RMW_WR: begin
        req.wr_en   = 1'b1;
        req.wr_addr = (op == OP_WAIT) ? oth : tgt;
        case (op)
          OP_BLOCK:   wdata.state = SLOT_LOCKED;
          OP_UNBLOCK: wdata.state = SLOT_READY;
          OP_WAIT: begin
            wdata.state   = SLOT_LOCKED;
            wdata.waiting = 1'b1;
            wdata.awaited = tgt;
          end
          default: wdata = mem_rdata;
        endcase
        req.wr_data = wdata;
        if (op == OP_UNBLOCK) begin
          state_next = S_RESP;
        end else begin
          scan_go = 1'b1;
        end
      end

      S_KILL_PAR: begin
        par_next = mem_rdata.parent;
        if (in_range(mem_rdata.parent, NSLOT)) begin
          req.rd_en   = 1'b1;
          req.rd_addr = mem_rdata.parent;
          state_next  = S_KILL_PCHK;
        end else begin
          // parent unreachable: free the slot right away
          wdata.state = SLOT_FREE;
          req.wr_en   = 1'b1;
          req.wr_addr = tgt;
          req.wr_data = wdata;
          scan_go     = 1'b1;
        end
      end

      S_KILL_PCHK: begin
        if (mem_rdata.waiting && (mem_rdata.awaited == tgt)) begin
          wdata.state   = SLOT_READY;
          wdata.waiting = 1'b0;
          wdata.awaited = '0;
          req.wr_en     = 1'b1;
          req.wr_addr   = par;
          req.wr_data   = wdata;
        end
        state_next = S_KILL_TRD;
      end

      S_KILL_TRD: begin
        // reread, since the parent may be the killed slot itself
        req.rd_en   = 1'b1;
        req.rd_addr = tgt;
        state_next  = S_KILL_TWR;
      end

      S_KILL_TWR: begin
        wdata.state = SLOT_FREE;
        req.wr_en   = 1'b1;
        req.wr_addr = tgt;
        req.wr_data = wdata;
        scan_go     = 1'b1;
      end

      S_SCAN: begin
        match = (op == OP_ADMIT) ? (mem_rdata.state == SLOT_FREE)
                                 : (mem_rdata.state == SLOT_READY);
        if (pend && match) begin
          if (op == OP_ADMIT) begin
            req.wr_en   = 1'b1;
            req.wr_addr = ID_W'(pend_addr);
            req.wr_data = '{state: SLOT_READY, waiting: 1'b0,
                            awaited: '0, parent: oth};
            new_id_next = ID_W'(pend_addr);
          end else begin
            running_next = pend_addr;
          end
          state_next = S_RESP;
        end else if (pend && (scan_cnt == SCAN_END)) begin
          status_next = (op == OP_ADMIT) ? STAT_FULL : STAT_NOREADY;
          state_next  = S_RESP;
        end else if (scan_cnt != SCAN_END) begin
          // stream one read per cycle, check it on the next
          req.rd_en      = 1'b1;
          req.rd_addr    = ID_W'(scan_addr);
          pend_next      = 1'b1;
          pend_addr_next = scan_addr;
          scan_addr_next = (scan_addr == LAST_IDX) ? '0 : scan_addr + 1'b1;
          scan_cnt_next  = scan_cnt + 1'b1;
        end
      end

      S_RESP: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (scan_go) begin
      state_next    = S_SCAN;
      scan_cnt_next = '0;
      if (op_next == OP_ADMIT) begin
        scan_addr_next = '0;
      end else begin
        // the running slot itself is tried last
        scan_addr_next = (running == LAST_IDX) ? '0 : running + 1'b1;
      end
    end
  end

  assign in_ready        = (state == S_IDLE);
  assign res_valid       = (state == S_RESP);
  assign res.running_pid = ID_W'(running);
  assign res.new_pid     = new_id;
  assign res.status      = status;

  a_running_in_range: assert property (@(posedge clk) disable iff (rst)
    int'(running) < NSLOT)
    else $error("running slot beyond table");

  a_running_moves_on_scan: assert property (@(posedge clk) disable iff (rst)
    (running != $past(running)) |-> $past(state == S_SCAN))
    else $error("running slot changed outside a scan");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    !(req.wr_en && req.rd_en && (req.wr_addr == req.rd_addr)))
    else $error("read and write to the same slot in one cycle");

  a_full_only_on_admit: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (status == STAT_FULL)) |-> (op == OP_ADMIT))
    else $error("table full reported for a non-admit event");

  a_new_id_only_on_admit: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (new_id != '0)) |-> (op == OP_ADMIT && status == STAT_OK))
    else $error("new id reported without a successful admit");

endmodule

FILE: src/round_robin_process_table.sv
// ----------------------------------------------------------------------------
// round_robin_process_table - process-slot table with round-robin scheduling
// One event is in work at a time. Undefined events answer directly, unblock
// after a read-modify-write, tick and admit after a slot scan, block and wait
// after both, kill after freeing the slot and waking a parent that waits on it,
// then a scan. The scan reads the NSLOT = min(SLOT_COUNT, 16) slots one per cycle.
// Reset: synchronous; all slots read as unassigned, running slot 0.
// ----------------------------------------------------------------------------
module round_robin_process_table
  import rrpt_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [3:0] target_pid, [7:4] other_pid
  input  logic [2:0]  s_tuser,   // [2:0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [3:0] running_pid, [7:4] new_pid, [9:8] status
);

  mem_req_t req;
  entry_t   mem_rdata;
  logic     res_valid;
  logic     res_ready;
  res_t     res;

  rrpt_ctrl #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_op    (op_t'(s_tuser)),
    .in_tgt   (s_tdata[3:0]),
    .in_oth   (s_tdata[7:4]),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .req      (req),
    .mem_rdata(mem_rdata)
  );

  rrpt_table #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_table (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rdata(mem_rdata)
  );

  // output register: load when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {6'b0, res.status, res.new_pid, res.running_pid};
    end
  end

endmodule

FILE: tb/round_robin_process_table_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// round_robin_process_table_check - scoreboard for the process table
// Watches both stream channels and tracks the slot table as event words are
// accepted. Each result word is compared with the oldest predicted result.
// It also exports which slots have been admitted and their recorded parents,
// so that stimulus can form wait/kill pairs and stay clear of unwritten
// parent entries.
// ----------------------------------------------------------------------------
module round_robin_process_table_check
  import rrpt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [7:0]       s_tdata,   // [3:0] target_pid, [7:4] other_pid
  input  logic [2:0]       s_tuser,   // [2:0] opcode
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [15:0]      m_tdata,   // [3:0] running_pid, [7:4] new_pid, [9:8] status
  output int               fail_count,
  output int               pending,
  output int               checked,
  output logic [15:0]      admitted_mask,
  output logic [15:0][3:0] parent_of
);

  localparam int NSLOT = 16;

  typedef struct {
    logic [3:0] running_pid;
    logic [3:0] new_pid;
    status_t    status;
  } sched_result_t;

  slot_state_t   slot_st  [16];
  logic          waiting  [16];
  logic [3:0]    awaited  [16];
  logic [3:0]    run_slot;
  sched_result_t sched_q  [$];
  sched_result_t exp_res;
  sched_result_t new_res;

  // Round-robin search starting after the running slot; the running slot
  // itself comes last.
  function automatic bit pick_next_ready();
    int idx;
    idx = int'(run_slot);
    for (int k = 0; k < NSLOT; k++) begin
      idx++;
      if (idx >= NSLOT) idx = 0;
      if (slot_st[idx] == SLOT_READY) begin
        run_slot = idx[3:0];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic apply_event(input logic [2:0] opc, input logic [3:0] tgt,
                             input logic [3:0] oth, output sched_result_t res);
    logic       resched;
    logic [3:0] par;
    res.new_pid = '0;
    res.status  = STAT_OK;
    resched     = 1'b0;
    case (opc)
      OP_TICK: begin
        resched = 1'b1;
      end
      OP_ADMIT: begin
        res.status = STAT_FULL;
        for (int i = 0; i < NSLOT; i++) begin
          if (slot_st[i] == SLOT_FREE) begin
            slot_st[i]       = SLOT_READY;
            waiting[i]       = 1'b0;
            awaited[i]       = '0;
            parent_of[i]     = oth;
            admitted_mask[i] = 1'b1;
            res.new_pid      = i[3:0];
            res.status       = STAT_OK;
            break;
          end
        end
      end
      OP_BLOCK: begin
        if (int'(tgt) < NSLOT) slot_st[tgt] = SLOT_LOCKED;
        resched = 1'b1;
      end
      OP_UNBLOCK: begin
        if (int'(tgt) < NSLOT) slot_st[tgt] = SLOT_READY;
      end
      OP_WAIT: begin
        if (int'(oth) < NSLOT) begin
          waiting[oth] = 1'b1;
          awaited[oth] = tgt;
          slot_st[oth] = SLOT_LOCKED;
        end
        resched = 1'b1;
      end
      OP_KILL: begin
        if (int'(tgt) < NSLOT) begin
          par = parent_of[tgt];
          // wake the parent only when it waits for exactly this slot
          if (int'(par) < NSLOT && waiting[par] && awaited[par] == tgt) begin
            waiting[par] = 1'b0;
            awaited[par] = '0;
            slot_st[par] = SLOT_READY;
          end
          slot_st[tgt] = SLOT_FREE;
        end
        resched = 1'b1;
      end
      default: ;
    endcase
    if (resched && !pick_next_ready()) res.status = STAT_NOREADY;
    res.running_pid = run_slot;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        slot_st[i]   = SLOT_FREE;
        waiting[i]   = 1'b0;
        awaited[i]   = '0;
        parent_of[i] = '0;
      end
      admitted_mask = '0;
      run_slot      = '0;
      sched_q.delete();
      fail_count    = 0;
      checked       = 0;
      pending       = 0;
    end else begin
      // a result never leaves in the cycle its event is accepted, so pop first
      if (m_tvalid && m_tready) begin
        if (sched_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result word %h", $realtime, m_tdata);
          fail_count++;
        end else begin
          exp_res = sched_q.pop_front();
          checked++;
          if (m_tdata[3:0] !== exp_res.running_pid || m_tdata[7:4] !== exp_res.new_pid ||
              m_tdata[9:8] !== exp_res.status) begin
            if (fail_count < 10)
              $display("%0t: result %0d: running %0d/%0d new %0d/%0d status %0d/%0d (exp/got)",
                       $realtime, checked, exp_res.running_pid, m_tdata[3:0],
                       exp_res.new_pid, m_tdata[7:4], exp_res.status, m_tdata[9:8]);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        apply_event(s_tuser, s_tdata[3:0], s_tdata[7:4], new_res);
        sched_q.push_back(new_res);
      end
      pending = sched_q.size();
    end
  end

endmodule

FILE: tb/round_robin_process_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// round_robin_process_table_test - top of the process table testbench
// Drives directed and then random scheduler events in bursts against a
// receiver with its own stall pattern, including one long hold-off. The
// checker instance predicts and compares; this module reports the verdict.
// ----------------------------------------------------------------------------
module round_robin_process_table_test;
  import rrpt_pkg::*;

  localparam int         RANDOM_EVENTS = 600;
  localparam int         HOLD_AT       = 300;
  localparam int         HOLD_CYCLES   = 400;
  localparam int         DRAIN_CYCLES  = 40;
  localparam int         CYCLE_LIMIT   = 200000;
  localparam logic [2:0] OP_UNDEF_A    = 3'd6;
  localparam logic [2:0] OP_UNDEF_B    = 3'd7;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [7:0]       s_tdata;
  logic [2:0]       s_tuser;
  logic             m_tvalid;
  logic             m_tready;
  logic [15:0]      m_tdata;
  int               fail_count;
  int               pending;
  int               checked;
  logic [15:0]      known_mask;
  logic [15:0][3:0] parent_tab;

  int   cycles;
  int   burst_left;
  int   events_sent;
  int   op_hist [8];
  int   rx_phase;
  int   last_child;
  logic hold_req;
  logic hold_done;

  round_robin_process_table i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  round_robin_process_table_check i_check (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked       (checked),
    .admitted_mask (known_mask),
    .parent_of     (parent_tab)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
    $display("round_robin_process_table: mismatch");
    $finish;
  end

  // Receiver: rotate through full rate, coin-flip and sparse ready, with one
  // long hold-off once the sender has had HOLD_AT events accepted.
  initial begin
    m_tready = 1'b0;
    rx_phase = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      rx_phase++;
      case ((rx_phase / 40) % 3)
        0:       m_tready = 1'b1;
        1:       m_tready = 1'($urandom_range(0, 1));
        default: m_tready = (rx_phase % 4 == 0);
      endcase
    end
  end

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_event(input logic [2:0] opc, input logic [3:0] tgt,
                            input logic [3:0] oth);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    s_tvalid = 1'b1;
    s_tuser  = opc;
    s_tdata  = {oth, tgt};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    events_sent++;
    op_hist[opc]++;
    if (events_sent == HOLD_AT) hold_req = 1'b1;
    @(negedge clk);
  endtask

  // Mostly meaningful events: kills only hit slots that have been admitted,
  // and waits often come from a slot's own parent so that kill wakes it.
  task automatic pick_event(output logic [2:0] opc, output logic [3:0] tgt,
                            output logic [3:0] oth);
    int   r;
    int   c;
    logic found;
    r     = $urandom_range(0, 99);
    tgt   = 4'($urandom_range(0, 15));
    oth   = 4'($urandom_range(0, 15));
    found = 1'b0;
    c     = $urandom_range(0, 15);
    for (int k = 0; k < 16 && !found; k++) begin
      if (known_mask[(c + k) % 16]) begin
        c     = (c + k) % 16;
        found = 1'b1;
      end
    end
    if (r < 15) begin
      opc = OP_TICK;
    end else if (r < 35) begin
      opc = OP_ADMIT;
    end else if (r < 43) begin
      opc = OP_BLOCK;
    end else if (r < 53) begin
      opc = OP_UNBLOCK;
    end else if (r < 68) begin
      opc = OP_WAIT;
      if (found && $urandom_range(0, 3) != 0) begin
        tgt        = c[3:0];
        oth        = parent_tab[c];
        last_child = c;
      end
    end else if (r < 92) begin
      if (found) begin
        opc = OP_KILL;
        tgt = c[3:0];
        if (last_child >= 0 && $urandom_range(0, 1) == 1) tgt = last_child[3:0];
      end else begin
        opc = OP_ADMIT;
      end
    end else begin
      opc = $urandom_range(0, 1) ? OP_UNDEF_A : OP_UNDEF_B;
    end
  endtask

  initial begin
    logic [2:0] opc;
    logic [3:0] tgt;
    logic [3:0] oth;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = '0;
    burst_left  = 0;
    events_sent = 0;
    last_child  = -1;
    hold_req    = 1'b0;
    hold_done   = 1'b0;
    foreach (op_hist[i]) op_hist[i] = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty table, undefined codes, wait/kill wake, fill to full, top slot
    send_event(OP_TICK, 4'd0, 4'd0);
    send_event(OP_UNDEF_A, 4'd15, 4'd15);
    send_event(OP_UNDEF_B, 4'd0, 4'd0);
    send_event(OP_ADMIT, 4'd0, 4'd0);
    send_event(OP_ADMIT, 4'd15, 4'd0);
    send_event(OP_WAIT, 4'd1, 4'd0);
    send_event(OP_KILL, 4'd1, 4'd15);
    repeat (15) send_event(OP_ADMIT, 4'd0, 4'd15);
    send_event(OP_ADMIT, 4'd0, 4'd15);
    send_event(OP_BLOCK, 4'd15, 4'd0);
    send_event(OP_UNBLOCK, 4'd15, 4'd0);
    send_event(OP_KILL, 4'd15, 4'd0);

    for (int n = 0; n < RANDOM_EVENTS; n++) begin
      pick_event(opc, tgt, oth);
      send_event(opc, tgt, oth);
    end
    s_tvalid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("events sent %0d: tick %0d admit %0d block %0d unblock %0d wait %0d kill %0d undef %0d",
             events_sent, op_hist[0], op_hist[1], op_hist[2], op_hist[3], op_hist[4],
             op_hist[5], op_hist[6] + op_hist[7]);
    $display("results compared %0d, long receiver hold %0s, failures %0d",
             checked, hold_done ? "done" : "skipped", fail_count);
    if (fail_count == 0) begin
      $display("round_robin_process_table: match");
    end else begin
      $display("round_robin_process_table: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/rrpt_pkg.sv
src/rrpt_table.sv
src/rrpt_ctrl.sv
src/round_robin_process_table.sv
tb/round_robin_process_table_check.sv
tb/round_robin_process_table_test.sv
